/* src/protection_region_lookup_top_assert.svh */
// ----------------------------------------------------------------------------
// protection region lookup assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef PROTECTION_REGION_LOOKUP_TOP_ASSERT_SVH
`define PROTECTION_REGION_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("protection region lookup check failed");

// next-cycle implication, sampled on clk, off during reset
`define PRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("protection region lookup check failed");

`endif

/* src/prl_pkg.sv */
// ----------------------------------------------------------------------------
// prl_pkg
// types, codes and the miss classifier for the protection region lookup
// ----------------------------------------------------------------------------
`default_nettype none

package prl_pkg;

    // slot index wide enough for the largest supported table (64 entries)
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int ADDR_W  = 32;
    localparam int TYPE_W  = 4;
    localparam int ATTR_W  = 6;
    localparam int INDEX_W = 4;
    localparam int REASON_W = 5;
    localparam int CFG_INDEX_W = 2;

    // request kinds
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MANAGER_READY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_USER_START    = 2'd1;

    localparam logic [ADDR_W-1:0] USER_START_RESET = 32'h4000_0000;

    // type codes used as defaults
    localparam logic [TYPE_W-1:0] TYPE_KDATA = 4'd1;
    localparam logic [TYPE_W-1:0] TYPE_USER  = 4'd8;

    // attribute bit positions
    localparam int ATTR_RO_BIT   = 4;
    localparam int ATTR_CRIT_BIT = 5;

    // reason classes
    localparam logic [REASON_W-1:0] RSN_NOTREADY = 5'd0;
    localparam logic [REASON_W-1:0] RSN_HIT      = 5'd1;
    localparam logic [REASON_W-1:0] RSN_NULL     = 5'd2;
    localparam logic [REASON_W-1:0] RSN_AA       = 5'd3;
    localparam logic [REASON_W-1:0] RSN_DE       = 5'd4;
    localparam logic [REASON_W-1:0] RSN_CC       = 5'd5;
    localparam logic [REASON_W-1:0] RSN_55       = 5'd6;
    localparam logic [REASON_W-1:0] RSN_FF       = 5'd7;
    localparam logic [REASON_W-1:0] RSN_FEED     = 5'd8;
    localparam logic [REASON_W-1:0] RSN_FACE     = 5'd9;
    localparam logic [REASON_W-1:0] RSN_DEAD     = 5'd10;
    localparam logic [REASON_W-1:0] RSN_BEEF     = 5'd11;
    localparam logic [REASON_W-1:0] RSN_8X       = 5'd12;
    localparam logic [REASON_W-1:0] RSN_HIGH     = 5'd13;
    localparam logic [REASON_W-1:0] RSN_USER     = 5'd14;
    localparam logic [REASON_W-1:0] RSN_KLOW     = 5'd15;
    localparam logic [REASON_W-1:0] RSN_UNKNOWN  = 5'd16;

    // request token travelling down the cell chain
    typedef struct packed {
        logic                kind;
        logic                add_ok;   // add: table had room at entry
        logic [SLOT_W-1:0]   slot;     // add: target cell; lookup: matched cell
        logic [COUNT_W-1:0]  count;    // lookup: regions stored at entry
        logic [ADDR_W-1:0]   addr;     // lookup address or region start
        logic [ADDR_W-1:0]   rend;     // region end on add
        logic [ATTR_W-1:0]   attr;     // add attributes or matched attributes
        logic                hit;
    } token_t;

    typedef struct packed {
        logic                accepted;
        logic                hit;
        logic [INDEX_W-1:0]  match_index;
        logic [TYPE_W-1:0]   match_type;
        logic                match_critical;
        logic                match_writable;
        logic [REASON_W-1:0] reason_class;
    } result_t;

    function automatic logic [REASON_W-1:0] miss_class(
        input logic [ADDR_W-1:0] a,
        input logic [ADDR_W-1:0] user_start
    );
        logic [7:0]  top8;
        logic [15:0] top16;
        logic [REASON_W-1:0] r;
        top8  = a[31:24];
        top16 = a[31:16];
        if (a < 32'h0000_1000)            r = RSN_NULL;
        else if (top8 == 8'hAA)           r = RSN_AA;
        else if (top8 == 8'hDE)           r = RSN_DE;
        else if (top8 == 8'hCC)           r = RSN_CC;
        else if (top8 == 8'h55)           r = RSN_55;
        else if (top8 == 8'hFF)           r = RSN_FF;
        else if (top16 == 16'hFEED)       r = RSN_FEED;
        else if (top16 == 16'hFACE)       r = RSN_FACE;
        else if (top16 == 16'hDEAD)       r = RSN_DEAD;
        else if (top16 == 16'hBEEF)       r = RSN_BEEF;
        else if (a[31:28] == 4'h8)        r = RSN_8X;
        else if (a >= 32'hC000_0000)      r = RSN_HIGH;
        else if (a >= user_start)         r = RSN_USER;
        else if (a >= 32'h0010_0000)      r = RSN_KLOW;
        else                              r = RSN_UNKNOWN;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/prl_cell.sv */
// ----------------------------------------------------------------------------
// prl_cell
// one region slot: stores an added range and tests passing lookups
// ----------------------------------------------------------------------------
`default_nettype none

module prl_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic            tok_valid_in,
    input  wire prl_pkg::token_t tok_in,
    output logic                 tok_valid_out,
    output prl_pkg::token_t      tok_out
);

    localparam logic [prl_pkg::SLOT_W-1:0]  MY_SLOT  = prl_pkg::SLOT_W'(CELL_INDEX);
    localparam logic [prl_pkg::COUNT_W-1:0] MY_COUNT = prl_pkg::COUNT_W'(CELL_INDEX);

    logic [prl_pkg::ADDR_W-1:0] start_reg;
    logic [prl_pkg::ADDR_W-1:0] end_reg;
    logic [prl_pkg::ATTR_W-1:0] attr_reg;

    logic            valid_reg;
    prl_pkg::token_t tok_reg;
    prl_pkg::token_t tok_next;
    logic            do_write;
    logic            match;

    assign do_write = advance && tok_valid_in && (tok_in.kind == prl_pkg::KIND_ADD)
                      && tok_in.add_ok && (tok_in.slot == MY_SLOT);

    // first match wins: only test if no earlier cell already hit
    assign match = (tok_in.kind == prl_pkg::KIND_LOOKUP) && !tok_in.hit
                   && (MY_COUNT < tok_in.count)
                   && (tok_in.addr >= start_reg) && (tok_in.addr < end_reg);

    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            tok_next.hit  = 1'b1;
            tok_next.slot = MY_SLOT;
            tok_next.attr = attr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            start_reg <= tok_in.addr;
            end_reg   <= tok_in.rend;
            attr_reg  <= tok_in.attr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= tok_valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            tok_reg <= tok_next;
    end

    assign tok_valid_out = valid_reg;
    assign tok_out       = tok_reg;

endmodule

`default_nettype wire

/* src/prl_out.sv */
// ----------------------------------------------------------------------------
// prl_out
// result stage: turns a finished token into a result and holds it
// ----------------------------------------------------------------------------
`default_nettype none

module prl_out (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic                        tok_valid,
    input  wire prl_pkg::token_t             tok,
    input  wire logic                        manager_ready,
    input  wire logic [prl_pkg::ADDR_W-1:0]  user_space_start,
    output logic                             res_valid,
    output prl_pkg::result_t                 res
);

    logic             valid_reg;
    prl_pkg::result_t res_reg;
    prl_pkg::result_t res_next;

    always_comb
    begin
        res_next = '0;
        if (tok.kind == prl_pkg::KIND_ADD)
        begin
            res_next.accepted = tok.add_ok;
        end
        else if (!manager_ready)
        begin
            res_next.match_type     = prl_pkg::TYPE_KDATA;
            res_next.match_critical = 1'b1;
            res_next.reason_class   = prl_pkg::RSN_NOTREADY;
        end
        else if (tok.hit)
        begin
            res_next.hit            = 1'b1;
            res_next.match_index    = prl_pkg::INDEX_W'(tok.slot);
            res_next.match_type     = tok.attr[prl_pkg::TYPE_W-1:0];
            res_next.match_critical = tok.attr[prl_pkg::ATTR_CRIT_BIT];
            res_next.match_writable = !tok.attr[prl_pkg::ATTR_RO_BIT];
            res_next.reason_class   = prl_pkg::RSN_HIT;
        end
        else
        begin
            res_next.match_type     = prl_pkg::TYPE_USER;
            res_next.match_critical = (tok.addr < user_space_start);
            res_next.reason_class   = prl_pkg::miss_class(tok.addr, user_space_start);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= tok_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* src/protection_region_lookup_top.sv */
// ----------------------------------------------------------------------------
// protection_region_lookup_top
// region table with first-match address classification
// ----------------------------------------------------------------------------
// The table is a chain of MAX_REGIONS cells, each holding one region. Every
// request (add or lookup) enters the chain and moves one cell per cycle while
// the chain is not held: an add writes its range into the cell picked at entry
// from the fill count, a lookup tests each cell it passes and keeps the first
// hit. The first cell registers the request at the accepting edge and the
// result is registered behind the last cell, and a new request can be accepted
// every cycle unless the chain is held. When a result is not taken the whole
// chain holds and in_ready drops. Requests stay in order, so an add is always
// seen by every lookup accepted after it. Lookups only test cells below the
// fill count seen at entry. Configuration writes (manager_ready,
// user_space_start) are taken every cycle and are used at the result stage;
// write them only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module protection_region_lookup_top #(
    parameter int MAX_REGIONS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             kind,
    input  wire logic [prl_pkg::ADDR_W-1:0]       address,
    input  wire logic [prl_pkg::ADDR_W-1:0]       region_start,
    input  wire logic [prl_pkg::ADDR_W-1:0]       region_end,
    input  wire logic [prl_pkg::TYPE_W-1:0]       region_code,
    input  wire logic                             region_read_only,
    input  wire logic                             region_critical,

    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  accepted,
    output logic                                  hit,
    output logic [prl_pkg::INDEX_W-1:0]           match_index,
    output logic [prl_pkg::TYPE_W-1:0]            match_type,
    output logic                                  match_critical,
    output logic                                  match_writable,
    output logic [prl_pkg::REASON_W-1:0]          reason_class,

    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [prl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [prl_pkg::ADDR_W-1:0]       cfg_data
);

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    // configuration registers
    logic                       manager_ready_reg;
    logic [prl_pkg::ADDR_W-1:0] user_start_reg;

    // fill count of the table
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // chain stall: everything moves when the result register is free or drained
    logic advance;
    logic in_fire;
    logic room;

    logic             chain_valid [MAX_REGIONS+1];
    prl_pkg::token_t  chain_tok   [MAX_REGIONS+1];

    prl_pkg::result_t res;

    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign room      = (count_reg < CNT_W'(MAX_REGIONS));

    // config writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manager_ready_reg <= 1'b0;
            user_start_reg    <= prl_pkg::USER_START_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == prl_pkg::CFG_MANAGER_READY)
                manager_ready_reg <= cfg_data[0];
            else if (cfg_index == prl_pkg::CFG_USER_START)
                user_start_reg <= cfg_data;
        end
    end

    // count bumps on every add that finds room
    always_comb
    begin
        count_next = count_reg;
        if (in_fire && (kind == prl_pkg::KIND_ADD) && room)
            count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // entry token: add carries its range in addr/rend, lookup its address
    always_comb
    begin
        chain_valid[0]      = in_fire;
        chain_tok[0].kind   = kind;
        chain_tok[0].add_ok = room;
        chain_tok[0].slot   = prl_pkg::SLOT_W'(count_reg);
        chain_tok[0].count  = prl_pkg::COUNT_W'(count_reg);
        chain_tok[0].addr   = (kind == prl_pkg::KIND_ADD) ? region_start : address;
        chain_tok[0].rend   = region_end;
        chain_tok[0].attr   = {region_critical, region_read_only, region_code};
        chain_tok[0].hit    = 1'b0;
    end

    // the region cells
    for (genvar g = 0; g < MAX_REGIONS; g++)
    begin : g_cell
        prl_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .tok_valid_in  (chain_valid[g]),
            .tok_in        (chain_tok[g]),
            .tok_valid_out (chain_valid[g+1]),
            .tok_out       (chain_tok[g+1])
        );
    end

    // result register behind the last cell
    prl_out u_out (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .tok_valid        (chain_valid[MAX_REGIONS]),
        .tok              (chain_tok[MAX_REGIONS]),
        .manager_ready    (manager_ready_reg),
        .user_space_start (user_start_reg),
        .res_valid        (out_valid),
        .res              (res)
    );

    assign accepted       = res.accepted;
    assign hit            = res.hit;
    assign match_index    = res.match_index;
    assign match_type     = res.match_type;
    assign match_critical = res.match_critical;
    assign match_writable = res.match_writable;
    assign reason_class   = res.reason_class;

endmodule

`default_nettype wire

/* src/prl_checker.sv */
// ----------------------------------------------------------------------------
// prl_checker
// port-level checks on the result channel of the protection region lookup
// ----------------------------------------------------------------------------
`default_nettype none

`include "protection_region_lookup_top_assert.svh"

module prl_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire logic                             accepted,
    input  wire logic                             hit,
    input  wire logic [prl_pkg::INDEX_W-1:0]      match_index,
    input  wire logic [prl_pkg::TYPE_W-1:0]       match_type,
    input  wire logic                             match_critical,
    input  wire logic                             match_writable,
    input  wire logic [prl_pkg::REASON_W-1:0]     reason_class
);

    // stored add: every other field is zero
    `PRL_ASSERT_IMPL(a_add_clean, out_valid && accepted,
        !hit && match_index == '0 && match_type == '0 && !match_critical
        && !match_writable && reason_class == prl_pkg::RSN_NOTREADY)

    // hit results carry the hit class and never an add flag
    `PRL_ASSERT_IMPL(a_hit_class, out_valid && hit,
        !accepted && reason_class == prl_pkg::RSN_HIT)

    // not-ready lookups give the fixed defaults
    `PRL_ASSERT_IMPL(a_notready,
        out_valid && reason_class == prl_pkg::RSN_NOTREADY && match_type != '0,
        match_type == prl_pkg::TYPE_KDATA && match_critical && !match_writable && !hit)

    // misses report index zero and no write permission
    `PRL_ASSERT_IMPL(a_miss_index, out_valid && !hit,
        match_index == '0 && !match_writable)

    // a stalled result holds
    `PRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(reason_class) && $stable(match_index) && $stable(hit))

endmodule

bind protection_region_lookup_top prl_checker u_prl_checker (.*);

`default_nettype wire
